// ----- hdl/rce_pkg.sv -----
package rce_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam int NUM_RESULTS = 4;
  localparam int RESULT_IDX_W = 2;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_ROOT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture pixel and read line store
    logic commit;      // form results, update window, counters and line store
    logic root_start;  // latch sum of squares of the current result
    logic root_step;   // one digit of the square root
    logic advance;     // step to the next queued result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_results;
    logic last_result;
    logic root_done;
  } dp_status_t;

endpackage

// ----- hdl/roberts_cross_edge_stream_top.sv -----
// Roberts cross edge detector over a raster stream of 8-bit pixels. A pixel
// is taken (with the line store read) and committed in the next, so a pixel
// that releases no result frees the input once it is committed. Each result
// it causes (0 to 4) then has its sum of squares latched, its square root
// found digit by digit in nine steps, and is held on the output until the
// beat is taken; a new pixel is taken only after its last result is taken.
// Results for pixel (x,y) appear when (x+1,y+1) is taken, clamped to the
// frame at its right and bottom edges, with run_last on the final one per
// input and frame_end on the frame's last pixel. Write image_width (index 0)
// and image_height (index 1) only while idle.
module roberts_cross_edge_stream_top #(
  parameter int MAX_WIDTH = rce_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [7:0]  pixel,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  diag_135_abs,
  output logic [7:0]  diag_45_abs,
  output logic [7:0]  edge_magnitude,
  output logic        frame_end,
  output logic        run_last
);

  rce_pkg::dp_cmd_t    cmd;
  rce_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  rce_ctrl u_ctrl (
    .clk, .rst, .pixel_valid, .pixel_ready, .result_ready, .result_valid,
    .cmd, .status
  );

  rce_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .pixel, .cmd, .status,
    .diag_135_abs, .diag_45_abs, .edge_magnitude, .frame_end, .run_last
  );

endmodule

// ----- hdl/rce_ctrl.sv -----
module rce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic                result_ready,
  output logic                result_valid,
  output rce_pkg::dp_cmd_t    cmd,
  input  rce_pkg::dp_status_t status
);

  rce_pkg::state_t state;
  rce_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rce_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rce_pkg::ST_IDLE: begin
        if (pixel_valid) state_next = rce_pkg::ST_READ;
      end
      rce_pkg::ST_READ: begin
        state_next = status.has_results ? rce_pkg::ST_START : rce_pkg::ST_IDLE;
      end
      rce_pkg::ST_START: begin
        state_next = rce_pkg::ST_ROOT;
      end
      rce_pkg::ST_ROOT: begin
        if (status.root_done) state_next = rce_pkg::ST_EMIT;
      end
      rce_pkg::ST_EMIT: begin
        if (result_ready) begin
          state_next = status.last_result ? rce_pkg::ST_IDLE : rce_pkg::ST_START;
        end
      end
      default: state_next = rce_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pixel_ready = 1'b0;
    result_valid = 1'b0;
    cmd = '0;
    case (state)
      rce_pkg::ST_IDLE: begin
        pixel_ready = 1'b1;
        cmd.load = pixel_valid;
      end
      rce_pkg::ST_READ: begin
        cmd.commit = 1'b1;
      end
      rce_pkg::ST_START: begin
        cmd.root_start = 1'b1;
      end
      rce_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      rce_pkg::ST_EMIT: begin
        result_valid = 1'b1;
        cmd.advance = result_ready;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/rce_dp.sv -----
module rce_dp #(
  parameter int MAX_WIDTH = rce_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          pixel,
  input  rce_pkg::dp_cmd_t    cmd,
  output rce_pkg::dp_status_t status,
  output logic [7:0]          diag_135_abs,
  output logic [7:0]          diag_45_abs,
  output logic [7:0]          edge_magnitude,
  output logic                frame_end,
  output logic                run_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int NR = rce_pkg::NUM_RESULTS;

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  line_store [MAX_WIDTH];
  logic [7:0]  upper;
  logic [7:0]  cur;
  logic [7:0]  a1, a2, c1, c2;
  logic [CW-1:0] column_count;
  logic [15:0] row_count;
  logic [CW-1:0] w_eff;
  logic [15:0] h_eff;
  logic [CW-1:0] col;
  logic        last_col, last_row;

  // queued results
  logic [7:0]  q_center [NR];
  logic [7:0]  q_dr [NR];
  logic [7:0]  q_dl [NR];
  logic [NR-1:0] q_valid;
  logic [NR-1:0] q_fend;
  logic [NR-1:0] q_valid_next_view;
  logic [rce_pkg::RESULT_IDX_W-1:0] q_idx_sel;

  // differences for the current slot
  logic [7:0]  d1_abs, d2_abs;
  logic [16:0] sumsq;
  logic signed [8:0] g1, g2;

  // square root unit
  logic [16:0] rt_op;
  logic [17:0] rt_res;
  logic [16:0] rt_one;
  logic [17:0] rt_trial;
  logic [17:0] rt_round;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rce_pkg::WIDTH_RESET;
      image_height <= rce_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rce_pkg::REG_WIDTH:  image_width <= cfg_data[10:0];
        rce_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (image_width < 11'd2) w_eff = CW'(2);
    else if ({21'd0, image_width} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    h_eff = (image_height < 16'd2) ? 16'd2 : image_height;
    col = (column_count >= w_eff) ? w_eff - CW'(1) : column_count;
    last_col = (col >= w_eff - CW'(1));
    last_row = (row_count >= h_eff - 16'd1);
  end

  // line store read and pixel capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upper <= line_store[col[AW-1:0]];
      cur <= pixel;
    end
    if (cmd.commit) line_store[col[AW-1:0]] <= cur;
  end

  // results released by the pixel being committed
  always_comb begin
    q_valid_next_view = '0;
    if (row_count != 16'd0) begin
      q_valid_next_view[0] = (col >= CW'(1));
      q_valid_next_view[1] = last_col;
      q_valid_next_view[2] = last_row && (col >= CW'(1));
      q_valid_next_view[3] = last_row && last_col;
    end
  end

  // window, counters and result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      a1 <= '0; a2 <= '0; c1 <= '0; c2 <= '0;
      column_count <= '0;
      row_count <= '0;
      q_valid <= '0;
    end else if (cmd.commit) begin
      q_valid <= q_valid_next_view;
      q_fend <= {1'b1, {(NR-1){1'b0}}};
      q_center[0] <= a1; q_dr[0] <= cur; q_dl[0] <= (col >= CW'(2)) ? c2 : cur;
      q_center[1] <= upper; q_dr[1] <= c1; q_dl[1] <= c1;
      q_center[2] <= c1; q_dr[2] <= upper; q_dl[2] <= (col >= CW'(2)) ? a2 : upper;
      q_center[3] <= cur; q_dr[3] <= a1; q_dl[3] <= a1;
      a1 <= upper; a2 <= a1; c1 <= cur; c2 <= c1;
      if (last_col) begin
        column_count <= '0;
        row_count <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= col + CW'(1);
      end
    end else if (cmd.advance) begin
      q_valid[q_idx_sel] <= 1'b0;
    end
  end

  // pick first pending slot
  always_comb begin
    q_idx_sel = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (q_valid[i]) q_idx_sel = rce_pkg::RESULT_IDX_W'(i);
    end
  end

  always_comb begin
    g1 = $signed({1'b0, q_dr[q_idx_sel]}) - $signed({1'b0, q_center[q_idx_sel]});
    g2 = $signed({1'b0, q_dl[q_idx_sel]}) - $signed({1'b0, q_center[q_idx_sel]});
    d1_abs = g1[8] ? 8'(-g1) : g1[7:0];
    d2_abs = g2[8] ? 8'(-g2) : g2[7:0];
    sumsq = 17'({8'd0, d1_abs} * {8'd0, d1_abs}) + 17'({8'd0, d2_abs} * {8'd0, d2_abs});
  end

  // square root, one result digit per step, nine steps
  assign rt_trial = rt_res + 18'(rt_one);

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rt_op <= sumsq;
      rt_res <= '0;
      rt_one <= 17'h10000;
    end else if (cmd.root_step) begin
      if ({1'b0, rt_op} >= rt_trial) begin
        rt_op <= 17'({1'b0, rt_op} - rt_trial);
        rt_res <= (rt_res >> 1) + 18'(rt_one);
      end else begin
        rt_res <= rt_res >> 1;
      end
      rt_one <= rt_one >> 2;
    end
  end

  // round to nearest: remainder above the root means up
  assign rt_round = rt_res + 18'({1'b0, rt_op} > rt_res);

  // results waiting after the current one
  logic [NR-1:0] later_mask;
  always_comb begin
    for (int i = 0; i < NR; i++) later_mask[i] = (i > int'(q_idx_sel));
  end

  assign status.has_results = |q_valid_next_view;
  assign status.last_result = ~|(q_valid & later_mask);
  assign status.root_done   = rt_one[0];

  assign diag_135_abs   = d1_abs;
  assign diag_45_abs    = d2_abs;
  assign edge_magnitude = (rt_round > 18'd255) ? 8'd255 : rt_round[7:0];
  assign frame_end      = q_fend[q_idx_sel];
  assign run_last       = status.last_result;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int MAXW = 1024;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] d135;
    logic [7:0] d45;
    logic [7:0] mag;
    logic       fend;
    logic       rlast;
  } edge_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = rce_pkg::REG_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        pixel_valid = 1'b0;
  logic        pixel_ready;
  logic [7:0]  pixel = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  diag_135_abs, diag_45_abs, edge_magnitude;
  logic        frame_end, run_last;

  roberts_cross_edge_stream_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .result_valid(result_valid), .result_ready(result_ready),
    .diag_135_abs(diag_135_abs), .diag_45_abs(diag_45_abs),
    .edge_magnitude(edge_magnitude), .frame_end(frame_end), .run_last(run_last)
  );

  always #6 clk = ~clk;

  // pixels waiting to be sent and results still owed by the block
  logic [7:0] pixel_q[$];
  edge_res_t  edge_q[$];

  // shadow of the block's registers and state
  logic [10:0] width_reg = rce_pkg::WIDTH_RESET;
  logic [15:0] height_reg = rce_pkg::HEIGHT_RESET;
  logic [7:0]  row_buf [MAXW];
  logic [31:0] win = '0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  int  send_idle = 0;
  int  recv_idle = 0;
  int  errors = 0;
  int  stall_cnt = 0;
  logic px_beat = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int  hold_cnt = 0;

  initial foreach (row_buf[i]) row_buf[i] = '0;

  function automatic logic [7:0] sat_abs(int v);
    int a;
    a = v < 0 ? -v : v;
    return a > 255 ? 8'd255 : a[7:0];
  endfunction

  function automatic logic [7:0] nearest_root(int unsigned n);
    int unsigned s;
    s = 0;
    while (s < 256 && (s + 1) * (s + 1) <= n) s++;
    if (n > s * s + s) s++;
    return s > 255 ? 8'd255 : s[7:0];
  endfunction

  function automatic void push_edge(logic [7:0] ctr, logic [7:0] dr, logic [7:0] dl,
                                    logic fe);
    edge_res_t r;
    int g1, g2;
    g1 = int'(dr) - int'(ctr);
    g2 = int'(dl) - int'(ctr);
    r.d135 = sat_abs(g1);
    r.d45 = sat_abs(g2);
    r.mag = nearest_root(g1 * g1 + g2 * g2);
    r.fend = fe;
    r.rlast = 1'b0;
    edge_q.push_back(r);
  endfunction

  // advance the shadow by one accepted pixel and queue the edges it releases
  function automatic void predict_edges(logic [7:0] cur);
    int unsigned w, h, c, n0;
    logic [7:0] a1, a2, c1, c2, up;
    logic lc, lr;
    edge_res_t t;
    w = width_reg < 2 ? 2 : width_reg;
    if (w > MAXW) w = MAXW;
    h = height_reg < 2 ? 2 : height_reg;
    c = col_cnt >= w ? w - 1 : col_cnt;
    lc = c >= w - 1;
    lr = row_cnt >= h - 1;
    a1 = win[7:0];
    a2 = win[15:8];
    c1 = win[23:16];
    c2 = win[31:24];
    up = row_buf[c];
    n0 = edge_q.size();
    if (row_cnt >= 1) begin
      if (c >= 1) push_edge(a1, cur, c >= 2 ? c2 : cur, 1'b0);
      if (lc) push_edge(up, c1, c1, 1'b0);
      if (lr) begin
        if (c >= 1) push_edge(c1, up, c >= 2 ? a2 : up, 1'b0);
        if (lc) push_edge(cur, a1, a1, 1'b1);
      end
    end
    if (edge_q.size() > n0) begin
      t = edge_q[$];
      t.rlast = 1'b1;
      edge_q[edge_q.size() - 1] = t;
    end
    win = {c1, cur, a1, up};
    row_buf[c] = cur;
    if (lc) begin
      col_cnt = 0;
      row_cnt = lr ? 0 : ((row_cnt + 1) & 16'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // predict on pixel beats, check result beats, watch for a hang
  always @(posedge clk) begin
    edge_res_t e, got;
    px_beat <= pixel_valid && pixel_ready;
    if (!rst) begin
      if (pixel_valid && pixel_ready) predict_edges(pixel);
      if (result_valid && result_ready) begin
        got = '{diag_135_abs, diag_45_abs, edge_magnitude, frame_end, run_last};
        if (edge_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", got);
        end else begin
          e = edge_q.pop_front();
          if (got !== e) begin
            errors++;
            if (errors <= 10)
              $display({"result: expected d135=%0d d45=%0d mag=%0d fe=%b rl=%b,",
                        " got d135=%0d d45=%0d mag=%0d fe=%b rl=%b"},
                       e.d135, e.d45, e.mag, e.fend, e.rlast,
                       got.d135, got.d45, got.mag, got.fend, got.rlast);
          end
        end
      end
      if ((pixel_valid && pixel_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("roberts_cross_edge_stream_top: mismatch");
        $finish;
      end
    end
  end

  // pixel driver: hold the beat until taken, idle at random
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || px_beat) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        pixel <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= 400;
      result_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= $urandom_range(99) >= recv_idle;
    end
  end

  task automatic write_reg(rce_pkg::reg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rce_pkg::REG_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || pixel_valid || edge_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixels(int n);
    for (int i = 0; i < n; i++) pixel_q.push_back(rand_pixel());
  endtask

  initial begin
    int w, h, sent;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // checkerboard of extremes on a 3x3 frame
    write_reg(rce_pkg::REG_WIDTH, 16'd3);
    write_reg(rce_pkg::REG_HEIGHT, 16'd3);
    for (int i = 0; i < 9; i++) pixel_q.push_back(i % 2 ? 8'd255 : 8'd0);
    drain();

    // width and height below range act as 2
    write_reg(rce_pkg::REG_WIDTH, 16'd0);
    write_reg(rce_pkg::REG_HEIGHT, 16'd1);
    pixel_q.push_back(8'd255); pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd0); pixel_q.push_back(8'd255);
    drain();

    // upper width bits are dropped; tall frame cut short by a height write
    write_reg(rce_pkg::REG_WIDTH, 16'hF802);
    write_reg(rce_pkg::REG_HEIGHT, 16'hFFFF);
    queue_pixels(80);
    drain();
    write_reg(rce_pkg::REG_HEIGHT, 16'd2);
    queue_pixels(2);
    drain();

    // random frames under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = mode == 0 ? 7 : (mode == 1 ? 61 : 0);
      recv_idle = mode == 0 ? 61 : (mode == 1 ? 7 : 0);
      sent = 0;
      while (sent < 110) begin
        w = $urandom_range(9, 2);
        h = $urandom_range(6, 2);
        write_reg(rce_pkg::REG_WIDTH, 16'(w));
        write_reg(rce_pkg::REG_HEIGHT, 16'(h));
        if (mode == 0 && sent == 0) hold_req = ~hold_req;
        queue_pixels(w * h);
        sent += w * h;
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("roberts_cross_edge_stream_top: match");
    else
      $display("roberts_cross_edge_stream_top: mismatch");
    $finish;
  end

endmodule
